// File: rtl/core/aes_ctr_pkg.sv
// aes_ctr_pkg: shared types, constants and functions of the counter-mode aes block
// no dependencies
package aes_ctr_pkg;

   localparam int MaxRoundKeys = 15;
   localparam int RkDepth = 2 * MaxRoundKeys;
   localparam int RkAddrW = $clog2(RkDepth);
   localparam int MaxWords = 4 * MaxRoundKeys;
   localparam int WordIdxW = $clog2(MaxWords + 1);
   localparam int RoundW = 4;

   localparam logic [2:0] CsrKeySize = 3'd0;
   localparam logic [2:0] CsrKey0 = 3'd1;
   localparam logic [2:0] CsrKey1 = 3'd2;
   localparam logic [2:0] CsrKey2 = 3'd3;
   localparam logic [2:0] CsrKey3 = 3'd4;
   localparam logic [2:0] CsrCtrHi = 3'd5;
   localparam logic [2:0] CsrCtrLo = 3'd6;

   localparam logic [7:0] RconInit = 8'h01;

   typedef logic [7:0] sbox_tab_type [256];
   localparam sbox_tab_type SboxTab = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_EXPAND = 6'b000010,
      ST_WHITEN = 6'b000100,
      ST_ROUND  = 6'b001000,
      ST_FINISH = 6'b010000,
      ST_OUT    = 6'b100000
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;       // latch the transaction
      logic exp_init;     // reload key schedule generator
      logic exp_step;     // produce one key word
      logic ctr_load;     // reload counter from csr
      logic rk_read;      // fetch round key halves
      logic whiten;       // state = counter ^ rk0
      logic round;        // one aes round
      logic finish;       // form the result
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic exp_done;
      logic last_round;
   } dp_stat_type;

   function automatic logic [7:0] xtime(input logic [7:0] b);
      xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SboxTab[w[31:24]], SboxTab[w[23:16]], SboxTab[w[15:8]], SboxTab[w[7:0]]};
   endfunction

endpackage

// File: rtl/core/aes_ctr_if.sv
// aes_ctr_req_if / aes_ctr_rsp_if: valid-ready channels of the cipher
// no dependencies
interface aes_ctr_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic [63:0] data_hi;
   logic [63:0] data_lo;
   logic [4:0]  byte_count;
   modport source (output valid, start_req, data_hi, data_lo, byte_count, input ready);
   modport sink (input valid, start_req, data_hi, data_lo, byte_count, output ready);
endinterface

interface aes_ctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_hi;
   logic [63:0] out_lo;
   logic [4:0]  out_count;
   modport source (output valid, out_hi, out_lo, out_count, input ready);
   modport sink (input valid, out_hi, out_lo, out_count, output ready);
endinterface

// File: rtl/core/aes_ctr_ctrl.sv
// aes_ctr_ctrl: sequencing state machine for key expansion, rounds and output
// depends on aes_ctr_pkg
module aes_ctr_ctrl import aes_ctr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_start,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);
   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_start) begin
                  cmd.exp_init = 1'b1;
                  cmd.ctr_load = 1'b1;
                  state_in = ST_EXPAND;
               end else begin
                  cmd.rk_read = 1'b1;
                  state_in = ST_WHITEN;
               end
            end
         end
         ST_EXPAND: begin
            if (stat.exp_done) begin
               cmd.rk_read = 1'b1;
               state_in = ST_WHITEN;
            end else begin
               cmd.exp_step = 1'b1;
            end
         end
         ST_WHITEN: begin
            cmd.whiten = 1'b1;
            cmd.rk_read = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            if (stat.last_round) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rk_read = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// File: rtl/core/aes_ctr_dp.sv
// aes_ctr_dp: key schedule generator, round key store, round unit and counter
// depends on aes_ctr_pkg
module aes_ctr_dp import aes_ctr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type cmd,
   output dp_stat_type stat,
   input  logic [1:0]  key_size,
   input  logic [63:0] key_word [4],
   input  logic [63:0] ctr_init_hi,
   input  logic [63:0] ctr_init_lo,
   input  logic [63:0] in_data_hi,
   input  logic [63:0] in_data_lo,
   input  logic [4:0]  in_count,
   output logic [63:0] out_hi,
   output logic [63:0] out_lo,
   output logic [4:0]  out_count
);
   logic [127:0] rk_ff;
   logic [RoundW-1:0] nr_ff, round_ff;
   logic [63:0] ctr_hi_ff, ctr_lo_ff;
   logic [127:0] st_ff, st_in;
   logic [127:0] data_ff;
   logic [4:0] count_ff;
   logic [127:0] res_ff;

   // key expansion: window of the last nk words (up to eight), one word per cycle
   logic [31:0] win_ff [8];
   logic [31:0] win_in [8];
   logic [WordIdxW-1:0] widx_ff, wtotal_ff;
   logic [3:0] nk_ff, kcnt_ff;
   logic [7:0] rcon_ff;
   logic [31:0] prev_w, new_w, tmp_w;
   logic [31:0] hold_ff;
   logic [3:0] nk_sel;
   logic [RoundW-1:0] nr_sel;
   logic [2:0] last_idx;

   always_comb begin
      case (key_size)
         2'd0: nk_sel = 4'd4;
         2'd1: nk_sel = 4'd6;
         default: nk_sel = 4'd8;
      endcase
      if (nk_sel > 4'd4 && 32'(nk_sel) + 32'd7 > 32'(MaxRoundKeys)) begin
         nk_sel = nk_sel - 4'd2;
      end
      if (nk_sel > 4'd4 && 32'(nk_sel) + 32'd7 > 32'(MaxRoundKeys)) begin
         nk_sel = nk_sel - 4'd2;
      end
      nr_sel = RoundW'(nk_sel + 4'd6);
   end

   assign last_idx = 3'(nk_ff - 4'd1);

   always_comb begin
      prev_w = win_ff[last_idx];
      tmp_w = prev_w;
      if (kcnt_ff == 4'd0) begin
         tmp_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_ff, 24'h0};
      end else if (nk_ff > 4'd6 && kcnt_ff == 4'd4) begin
         tmp_w = sub_word(prev_w);
      end
      new_w = win_ff[0] ^ tmp_w;
      for (int i = 0; i < 7; i++) begin
         win_in[i] = win_ff[i + 1];
      end
      win_in[7] = win_ff[7];
      win_in[last_idx] = new_w;
   end

   // store write: initial nk words and generated words go out as pairs
   logic wr_en;
   logic [RkAddrW-1:0] wr_addr;
   logic [63:0] wr_data;
   logic [31:0] out_w;
   logic [WordIdxW-1:0] emit_ff;

   always_comb begin
      // word being emitted this step: initial key words first, then generated
      if (emit_ff < WordIdxW'(nk_ff)) begin
         out_w = win_ff[emit_ff[2:0]];
      end else begin
         out_w = new_w;
      end
      wr_en = cmd.exp_step && emit_ff[0];
      wr_addr = RkAddrW'(emit_ff >> 1);
      wr_data = {hold_ff, out_w};
   end

   assign stat.exp_done = (emit_ff == wtotal_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nr_ff <= RoundW'(10);
         emit_ff <= '0;
         wtotal_ff <= '0;
      end else if (cmd.exp_init) begin
         nr_ff <= nr_sel;
         emit_ff <= '0;
         wtotal_ff <= WordIdxW'(4 * (32'(nr_sel) + 1));
      end else if (cmd.exp_step) begin
         emit_ff <= emit_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_init) begin
         for (int i = 0; i < 8; i++) begin
            win_ff[i] <= i[0] ? key_word[i >> 1][31:0] : key_word[i >> 1][63:32];
         end
         nk_ff <= nk_sel;
         kcnt_ff <= '0;
         rcon_ff <= RconInit;
      end else if (cmd.exp_step) begin
         hold_ff <= out_w;
         if (emit_ff >= WordIdxW'(nk_ff)) begin
            win_ff <= win_in;
            if (kcnt_ff == nk_ff - 4'd1) begin
               kcnt_ff <= '0;
            end else begin
               kcnt_ff <= kcnt_ff + 1'b1;
            end
            if (kcnt_ff == 4'd0) begin
               rcon_ff <= xtime(rcon_ff);
            end
         end
      end
   end

   // round key read: fetch whole key as one 128-bit word from two banks
   logic [63:0] rk_hi_mem [MaxRoundKeys];
   logic [63:0] rk_lo_mem [MaxRoundKeys];
   logic [RoundW-1:0] rk_idx_ff, rd_idx;

   // a new transaction always starts from round key 0
   assign rd_idx = cmd.accept ? '0 : rk_idx_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         if (wr_addr[0]) begin
            rk_lo_mem[wr_addr[RkAddrW-1:1]] <= wr_data;
         end else begin
            rk_hi_mem[wr_addr[RkAddrW-1:1]] <= wr_data;
         end
      end
      if (cmd.rk_read) begin
         rk_ff <= {rk_hi_mem[rd_idx], rk_lo_mem[rd_idx]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rk_idx_ff <= '0;
      end else if (cmd.accept || cmd.rk_read) begin
         rk_idx_ff <= rd_idx + RoundW'(cmd.rk_read);
      end
   end

   // round unit
   logic [7:0] sb [16];
   logic [7:0] sr [16];
   logic [7:0] mc [16];
   logic [127:0] sr_v, mc_v;
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[i] = SboxTab[st_ff[127 - 8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            sr[4*c + i] = sb[4*((c + i) % 4) + i];
         end
      end
      for (int c = 0; c < 4; c++) begin
         logic [7:0] a0, a1, a2, a3, al;
         a0 = sr[4*c]; a1 = sr[4*c+1]; a2 = sr[4*c+2]; a3 = sr[4*c+3];
         al = a0 ^ a1 ^ a2 ^ a3;
         mc[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
         mc[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
         mc[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
         mc[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
      for (int i = 0; i < 16; i++) begin
         sr_v[127 - 8*i -: 8] = sr[i];
         mc_v[127 - 8*i -: 8] = mc[i];
      end
      st_in = st_ff;
      if (cmd.whiten) begin
         st_in = {ctr_hi_ff, ctr_lo_ff} ^ rk_ff;
      end else if (cmd.round) begin
         st_in = (stat.last_round ? sr_v : mc_v) ^ rk_ff;
      end
   end

   assign stat.last_round = (round_ff == nr_ff);

   logic [4:0] cnt_sat;
   logic [127:0] mask;
   assign cnt_sat = (in_count > 5'd16) ? 5'd16 : in_count;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         mask[127 - 8*i -: 8] = (5'(i) < count_ff) ? 8'hff : 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.accept) begin
         data_ff <= {in_data_hi, in_data_lo};
         count_ff <= cnt_sat;
      end
      if (cmd.finish) begin
         res_ff <= (data_ff ^ st_ff) & mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         ctr_hi_ff <= '0;
         ctr_lo_ff <= '0;
      end else begin
         if (cmd.whiten) begin
            round_ff <= RoundW'(1);
         end else if (cmd.round) begin
            round_ff <= round_ff + 1'b1;
         end
         if (cmd.ctr_load) begin
            ctr_hi_ff <= ctr_init_hi;
            ctr_lo_ff <= ctr_init_lo;
         end else if (cmd.finish) begin
            {ctr_hi_ff, ctr_lo_ff} <= {ctr_hi_ff, ctr_lo_ff} + 128'd1;
         end
      end
   end

   assign out_hi = res_ff[127:64];
   assign out_lo = res_ff[63:0];
   assign out_count = count_ff;
endmodule

// File: rtl/core/aes_ctr_stream_cipher_top.sv
// aes_ctr_stream_cipher_top: aes-ctr 128/192/256 with apb csr port
// each transaction whitens the counter, runs nr rounds (nr = 10, 12 or 14)
// at one round per cycle in the shared round unit and then forms the result;
// a new block is accepted only after the last result has been taken; a start
// transaction first expands the key schedule, one key word per cycle (44 to 60 words)
// synchronous active-high reset clears control, csr registers and the counter
module aes_ctr_stream_cipher_top import aes_ctr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   aes_ctr_req_if.sink   req,
   aes_ctr_rsp_if.source rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   logic [1:0]  key_size_ff;
   logic [63:0] key_ff [4];
   logic [63:0] ctr_hi_ff, ctr_lo_ff;
   logic [2:0]  csr_idx;
   ctl_cmd_type cmd;
   dp_stat_type stat;

   assign csr_pready = 1'b1;
   assign csr_idx = csr_paddr[5:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_size_ff <= '0;
         key_ff <= '{default: '0};
         ctr_hi_ff <= '0;
         ctr_lo_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_idx)
            CsrKeySize: key_size_ff <= csr_pwdata[1:0];
            CsrKey0: key_ff[0] <= csr_pwdata;
            CsrKey1: key_ff[1] <= csr_pwdata;
            CsrKey2: key_ff[2] <= csr_pwdata;
            CsrKey3: key_ff[3] <= csr_pwdata;
            CsrCtrHi: ctr_hi_ff <= csr_pwdata;
            CsrCtrLo: ctr_lo_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CsrKeySize: csr_prdata = {62'h0, key_size_ff};
         CsrKey0: csr_prdata = key_ff[0];
         CsrKey1: csr_prdata = key_ff[1];
         CsrKey2: csr_prdata = key_ff[2];
         CsrKey3: csr_prdata = key_ff[3];
         CsrCtrHi: csr_prdata = ctr_hi_ff;
         CsrCtrLo: csr_prdata = ctr_lo_ff;
         default: csr_prdata = '0;
      endcase
   end

   aes_ctr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_start(req.start_req), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .stat(stat), .cmd(cmd)
   );

   aes_ctr_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .key_size(key_size_ff), .key_word(key_ff),
      .ctr_init_hi(ctr_hi_ff), .ctr_init_lo(ctr_lo_ff),
      .in_data_hi(req.data_hi), .in_data_lo(req.data_lo),
      .in_count(req.byte_count),
      .out_hi(rsp.out_hi), .out_lo(rsp.out_lo), .out_count(rsp.out_count)
   );
endmodule
